// File: rtl/gce_pkg.sv
// shared widths, register indexes, mode codes and result constants
// of the correlation moment estimator; no dependencies
package gce_pkg;

  // field widths
  localparam int RES_W      = 16;
  localparam int RHO_W      = 18;
  localparam int MODE_W     = 2;
  localparam int VPC_W      = 9;
  localparam int PC_W       = 8;
  localparam int DISP_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // default cluster size limit
  localparam int DEF_MAX_VALUES = 256;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VPC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PC   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP = 2'd3;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_INDEP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EXCH  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AR1   = 2'd2;

  // register reset values
  localparam logic [VPC_W-1:0]  VPC_RESET  = 9'd2;
  localparam logic [DISP_W-1:0] DISP_RESET = 16'd256;

  // q1.16 constants
  localparam logic signed [RHO_W-1:0] FB_EXCH = 18'sd52429;  // 0.8
  localparam logic signed [RHO_W-1:0] FB_AR1  = 18'sd32768;  // 0.5
  localparam int                      ONE_Q16 = 65536;       // 1.0

endpackage

// File: rtl/gce_if.sv
// valid/ready channel interfaces: residual input, estimate output, config writes
// depends on gce_pkg
interface gce_in_if import gce_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] residual;
  logic                    last;

  modport source (output valid, residual, last, input ready);
  modport sink   (input valid, residual, last, output ready);
endinterface

interface gce_out_if import gce_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RHO_W-1:0] rho;
  logic                    fallback_used;

  modport source (output valid, rho, fallback_used, input ready);
  modport sink   (input valid, rho, fallback_used, output ready);
endinterface

interface gce_cfg_if import gce_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/gee_correlation_estimator.sv
// working-correlation moment estimator, top level
// depends on gce_pkg and the channel interfaces in gce_if.sv
//
// Residuals (signed Q8.8) stream in cluster order, values_per_cluster words per
// cluster. Exchangeable mode accumulates the running cluster sum times each new
// residual, ar1 mode the product with the previous residual of the same
// cluster; the 64-bit total saturates. The word marked last closes the data
// set: the total is divided by (pairs - parameter_count) * dispersion, the
// Q1.16 estimate is range checked, and one result word goes out, either the
// estimate or the fallback (0.8 exchangeable, 0.5 ar1) with fallback_used set.
// Independence mode always answers 0. One signed 26x18 multiplier with a
// registered product is shared by everything: the per-residual product, the
// pair count, the denominator (two half products) and the lower range test.
// A residual without last occupies the block while it is accepted and then
// accumulated into the total. The last residual also runs the finishing
// steps in exchangeable and ar1 mode, among them the shift-subtract divider
// (one quotient bit per cycle), and goes straight to the result step in
// independence mode; the result step waits while an earlier result word is
// still held in the output register. in ready is high only between items; a
// finished result sits in the output register and does not hold up the next
// residual. Configuration writes are always taken.
module gee_correlation_estimator import gce_pkg::*; #(
  parameter int MAX_VALUES_PER_CLUSTER = DEF_MAX_VALUES
) (
  input  logic       clk,
  input  logic       rst_n,
  gce_in_if.sink     in_ch,
  gce_out_if.source  out_ch,
  gce_cfg_if.sink    cfg_ch
);

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;   // waiting for a residual
  localparam logic [3:0] S_ACC   = 4'd1;   // add product into total
  localparam logic [3:0] S_PER   = 4'd2;   // pairs per cluster
  localparam logic [3:0] S_PAIRS = 4'd3;   // clusters times pairs per cluster
  localparam logic [3:0] S_SUB   = 4'd4;   // minus parameter count
  localparam logic [3:0] S_MLO   = 4'd5;   // low half times dispersion
  localparam logic [3:0] S_MHI   = 4'd6;   // high half times dispersion
  localparam logic [3:0] S_DEN   = 4'd7;   // assemble denominator, load divider
  localparam logic [3:0] S_DIV   = 4'd8;   // one quotient bit per cycle
  localparam logic [3:0] S_CHK   = 4'd9;   // quotient times (dim - 1), ar1 times 1
  localparam logic [3:0] S_RES   = 4'd10;  // range test, load output word

  localparam int          DIV_STEPS = 19;  // quotient bits 18 down to 0
  localparam logic [4:0]  DIV_LAST  = 5'(DIV_STEPS - 1);

  // configuration registers
  logic [MODE_W-1:0] mode_r;
  logic [VPC_W-1:0]  vpc_r;
  logic [PC_W-1:0]   pc_r;
  logic [DISP_W-1:0] disp_r;

  // data set state
  logic signed [23:0] cs_r;       // running cluster sum, q16.8
  logic signed [15:0] prev_r;     // previous residual
  logic signed [63:0] num_r;      // product total, q48.16
  logic [VPC_W-1:0]   pos_r;      // position in cluster
  logic [23:0]        count_r;    // completed clusters

  // sequencer and finishing registers
  logic [3:0]         state_r, state_nxt;
  logic               last_r;
  logic               indep_r;
  logic [24:0]        clusters_r;
  logic               pneg_r;     // pair count negative
  logic [41:0]        pmag_r;     // pair count magnitude
  logic [36:0]        lo_r;       // low half of denominator product
  logic [71:0]        rem_r;      // divider remainder
  logic [75:0]        dvs_r;      // shifted divisor
  logic [18:0]        q_r;        // quotient, q1.16 magnitude plus overflow bit
  logic [4:0]         div_cnt_r;
  logic               neg_r;
  logic               den_zero_r;
  logic signed [43:0] prod_r;     // shared multiplier output

  // output register
  logic                    out_valid_r;
  logic signed [RHO_W-1:0] rho_r;
  logic                    fb_r;

  // combinational helpers
  logic [VPC_W-1:0]   dim, dim_m1, pos_eff;
  logic signed [23:0] cs_eff;
  logic signed [24:0] cs_sum;
  logic [VPC_W:0]     pos_inc;
  logic               accept, out_free;
  logic signed [25:0] mul_a;
  logic signed [17:0] mul_b;
  logic [16:0]        per;
  logic signed [43:0] pairs;
  logic [64:0]        acc_sum;
  logic [63:0]        num_mag;
  logic [57:0]        den_sum;
  logic               div_ge;
  logic signed [RHO_W-1:0] res_rho;
  logic               res_fb;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.rho          = rho_r;
  assign out_ch.fallback_used = fb_r;

  // effective cluster size, clamped to [2, MAX_VALUES_PER_CLUSTER]
  always_comb begin
    if (vpc_r < 9'd2) begin
      dim = 9'd2;
    end else if (int'(vpc_r) > MAX_VALUES_PER_CLUSTER) begin
      dim = VPC_W'(MAX_VALUES_PER_CLUSTER);
    end else begin
      dim = vpc_r;
    end
  end
  assign dim_m1 = dim - 9'd1;

  // a size change can leave the position past the end: restart the cluster
  assign pos_eff = (pos_r >= dim) ? '0 : pos_r;
  assign cs_eff  = (pos_eff == '0) ? '0 : cs_r;
  assign cs_sum  = 25'(cs_eff) + 25'(in_ch.residual);
  assign pos_inc = {1'b0, pos_eff} + 10'd1;

  // pairs per cluster from the product of the previous cycle
  assign per = (mode_r == MODE_EXCH) ? prod_r[17:1] : prod_r[16:0];

  assign pairs   = prod_r - $signed({36'b0, pc_r});
  assign acc_sum = {num_r[63], num_r} + {{21{prod_r[43]}}, prod_r};
  assign num_mag = num_r[63] ? (64'd0 - num_r) : num_r;
  assign den_sum = {21'b0, lo_r} + {prod_r[36:0], 21'b0};
  assign div_ge  = ({4'b0, rem_r} >= dvs_r);

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_IDLE: begin
        if (mode_r == MODE_EXCH) begin
          mul_a = 26'(cs_eff);
          mul_b = 18'(in_ch.residual);
        end else if (mode_r == MODE_AR1 && pos_eff != '0) begin
          mul_a = 26'(prev_r);
          mul_b = 18'(in_ch.residual);
        end
      end
      S_PER: begin
        if (mode_r == MODE_EXCH) begin
          mul_a = {17'b0, dim};
          mul_b = {9'b0, dim_m1};
        end else begin
          mul_a = {17'b0, dim_m1};
          mul_b = 18'sd1;
        end
      end
      S_PAIRS: begin
        mul_a = {1'b0, clusters_r};
        mul_b = {1'b0, per};
      end
      S_MLO: begin
        mul_a = {5'b0, pmag_r[20:0]};
        mul_b = {2'b0, disp_r};
      end
      S_MHI: begin
        mul_a = {5'b0, pmag_r[41:21]};
        mul_b = {2'b0, disp_r};
      end
      S_CHK, S_RES: begin
        // lower bound test: q > floor(1/(dim-1)) exactly when q*(dim-1) > 1
        // kept through the result step while the output word waits
        mul_a = {8'b0, q_r[17:0]};
        mul_b = (mode_r == MODE_EXCH) ? {9'b0, dim_m1} : 18'sd1;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // range test and fallback selection
  always_comb begin
    res_rho = '0;
    res_fb  = 1'b0;
    if (indep_r) begin
      res_rho = '0;
    end else if (den_zero_r || q_r[18]) begin
      res_fb = 1'b1;
    end else if (q_r == '0) begin
      res_rho = '0;
    end else if (neg_r) begin
      if (prod_r > 44'sd65536) res_fb = 1'b1;
      else res_rho = -$signed(q_r[17:0]);
    end else begin
      if (int'(q_r) > ONE_Q16) res_fb = 1'b1;
      else res_rho = $signed(q_r[17:0]);
    end
    if (res_fb) res_rho = (mode_r == MODE_EXCH) ? FB_EXCH : FB_AR1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_ACC;
      S_ACC: begin
        if (!last_r) state_nxt = S_IDLE;
        else if (mode_r == MODE_EXCH || mode_r == MODE_AR1) state_nxt = S_PER;
        else state_nxt = S_RES;
      end
      S_PER:   state_nxt = S_PAIRS;
      S_PAIRS: state_nxt = S_SUB;
      S_SUB:   state_nxt = S_MLO;
      S_MLO:   state_nxt = S_MHI;
      S_MHI:   state_nxt = S_DEN;
      S_DEN:   state_nxt = S_DIV;
      S_DIV:   if (div_cnt_r == DIV_LAST) state_nxt = S_CHK;
      S_CHK:   state_nxt = S_RES;
      S_RES:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_INDEP;
      vpc_r  <= VPC_RESET;
      pc_r   <= '0;
      disp_r <= DISP_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_MODE: mode_r <= cfg_ch.data[MODE_W-1:0];
        CFG_VPC:  vpc_r  <= cfg_ch.data[VPC_W-1:0];
        CFG_PC:   pc_r   <= cfg_ch.data[PC_W-1:0];
        CFG_DISP: disp_r <= cfg_ch.data[DISP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer, data set state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cs_r        <= '0;
      prev_r      <= '0;
      num_r       <= '0;
      pos_r       <= '0;
      count_r     <= '0;
      last_r      <= 1'b0;
      indep_r     <= 1'b0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // a new word replaces the old one, else a taken word empties the register
      if (state_r == S_RES && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            last_r <= in_ch.last;
            prev_r <= in_ch.residual;
            if (pos_inc >= {1'b0, dim}) begin
              // cluster complete
              pos_r <= '0;
              cs_r  <= '0;
              if (count_r != '1) count_r <= count_r + 24'd1;
            end else begin
              pos_r <= pos_inc[VPC_W-1:0];
              if (cs_sum[24] != cs_sum[23]) cs_r <= cs_sum[24] ? 24'sh800000 : 24'sh7FFFFF;
              else cs_r <= cs_sum[23:0];
            end
          end
        end
        S_ACC: begin
          // saturating add into the 64-bit total
          if (acc_sum[64] != acc_sum[63]) begin
            num_r <= acc_sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
          end else begin
            num_r <= acc_sum[63:0];
          end
          indep_r <= !(mode_r == MODE_EXCH || mode_r == MODE_AR1);
        end
        S_DEN:  div_cnt_r <= '0;
        S_DIV:  div_cnt_r <= div_cnt_r + 5'd1;
        S_RES: begin
          if (out_free) begin
            cs_r        <= '0;
            prev_r      <= '0;
            num_r       <= '0;
            pos_r       <= '0;
            count_r     <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      S_ACC:   clusters_r <= {1'b0, count_r} + {24'b0, (pos_r != '0)};
      S_SUB: begin
        pneg_r <= pairs[43];
        pmag_r <= pairs[43] ? 42'(-pairs) : pairs[41:0];
      end
      S_MHI:   lo_r <= prod_r[36:0];
      S_DEN: begin
        rem_r      <= {num_mag, 8'b0};
        dvs_r      <= {den_sum, 18'b0};
        den_zero_r <= (den_sum == '0);
        neg_r      <= num_r[63] ^ pneg_r;
        q_r        <= '0;
      end
      S_DIV: begin
        if (div_ge) rem_r <= rem_r - dvs_r[71:0];
        q_r   <= {q_r[17:0], div_ge};
        dvs_r <= {1'b0, dvs_r[75:1]};
      end
      S_RES: begin
        if (out_free) begin
          rho_r <= res_rho;
          fb_r  <= res_fb;
        end
      end
      default: begin
      end
    endcase
  end

  // an accepted residual always keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("input taken twice in a row");

  // a result word appears only out of the result step
  a_out_from_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RES)
    else $error("result word without a finished data set");

  // a flagged result carries one of the fallback constants
  a_fb_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && fb_r) |-> (rho_r == FB_EXCH || rho_r == FB_AR1))
    else $error("fallback flag with a non-default estimate");

  // the data set state is cleared once its result is loaded
  a_clear_after_res: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES && out_free) |=> (num_r == '0 && count_r == '0 && pos_r == '0))
    else $error("data set state not cleared after result");

  // the divider never runs past its last bit
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_cnt_r <= DIV_LAST))
    else $error("divider ran past its last bit");

endmodule

// File: tb/sv/gce_estimate_check.sv
// result checker for the correlation moment estimator: follows register writes
// and residual words, predicts every estimate word and compares it on arrival
// depends on gce_pkg and the channel interfaces in gce_if.sv
module gce_estimate_check import gce_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  gce_in_if    in_mon,
  gce_out_if   out_mon,
  gce_cfg_if   cfg_mon,
  output int   fail_count,
  output int   open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [RHO_W-1:0] rho;
    logic                    fallback_used;
  } estimate_t;

  localparam logic signed [63:0] TOTAL_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] TOTAL_MIN = {1'b1, {63{1'b0}}};
  localparam longint             SUM_MAX   = 8388607;
  localparam longint             SUM_MIN   = -8388608;
  localparam logic [23:0]        COUNT_MAX = 24'hFFFFFF;

  logic [MODE_W-1:0]       reg_mode;
  logic [VPC_W-1:0]        reg_vpc;
  logic [PC_W-1:0]         reg_pc;
  logic [DISP_W-1:0]       reg_disp;
  logic signed [23:0]      run_sum;
  logic signed [RES_W-1:0] prev_res;
  logic signed [63:0]      pair_total;
  logic [VPC_W-1:0]        pos;
  logic [23:0]             clusters_done;
  estimate_t               rho_due[$];
  int                      fails = 0;
  int                      backlog = 0;

  assign fail_count = fails;
  assign open_count = backlog;

  function automatic int unsigned cluster_dim();
    if (reg_vpc < 2) return 2;
    if (reg_vpc > DEF_MAX_VALUES) return DEF_MAX_VALUES;
    return reg_vpc;
  endfunction

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? TOTAL_MIN : TOTAL_MAX;
    return s[63:0];
  endfunction

  // num * 256 / den toward zero; rejected above 256 whole units or outside [-low, 1.0]
  function automatic bit scaled_quotient(longint num, longint den, int unsigned low,
                                         output logic signed [RHO_W-1:0] q_out);
    bit [63:0] a, b;
    bit [71:0] q;
    q_out = '0;
    if (den == 0) return 1'b0;
    a = (num < 0) ? -num : num;
    b = (den < 0) ? -den : den;
    if (a / b > 64'd256) return 1'b0;
    q = {a, 8'h00} / {8'h00, b};
    if (q == 0) return 1'b1;
    q_out = q[RHO_W-1:0];
    if ((num < 0) != (den < 0)) begin
      if (q > low) return 1'b0;
      q_out = -q_out;
    end else if (q > ONE_Q16) begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_totals();
    run_sum       = '0;
    prev_res      = '0;
    pair_total    = '0;
    pos           = '0;
    clusters_done = '0;
  endfunction

  function automatic void absorb_residual(logic signed [RES_W-1:0] x, logic close,
                                          output bit emit, output estimate_t est);
    int unsigned             dim, per, low;
    longint                  s, clusters, pairs, den;
    logic signed [RHO_W-1:0] q;
    bit                      exch;
    dim  = cluster_dim();
    emit = 1'b0;
    est  = '0;
    if (pos >= dim) pos = '0;
    if (pos == 0) run_sum = '0;
    if (reg_mode == MODE_EXCH)
      pair_total = add_sat(pair_total, longint'(run_sum) * longint'(x));
    else if (reg_mode == MODE_AR1 && pos != 0)
      pair_total = add_sat(pair_total, longint'(prev_res) * longint'(x));
    s = longint'(run_sum) + longint'(x);
    if (s > SUM_MAX) s = SUM_MAX;
    if (s < SUM_MIN) s = SUM_MIN;
    run_sum  = s[23:0];
    prev_res = x;
    pos      = pos + 1'b1;
    if (pos >= dim) begin
      pos     = '0;
      run_sum = '0;
      if (clusters_done != COUNT_MAX) clusters_done = clusters_done + 1'b1;
    end
    if (!close) return;
    emit = 1'b1;
    exch = (reg_mode == MODE_EXCH);
    if (exch || reg_mode == MODE_AR1) begin
      clusters = longint'(clusters_done) + ((pos != 0) ? 1 : 0);
      per      = exch ? dim * (dim - 1) / 2 : dim - 1;
      pairs    = clusters * longint'(per) - longint'(reg_pc);
      den      = pairs * longint'(reg_disp);
      low      = exch ? ONE_Q16 / (dim - 1) : ONE_Q16;
      if (scaled_quotient(pair_total, den, low, q)) begin
        est.rho = q;
      end else begin
        est.rho           = exch ? FB_EXCH : FB_AR1;
        est.fallback_used = 1'b1;
      end
    end
    clear_totals();
  endfunction

  always @(posedge clk) begin
    bit        emit;
    estimate_t est, due;
    if (!rst_n) begin
      reg_mode = MODE_INDEP;
      reg_vpc  = VPC_RESET;
      reg_pc   = '0;
      reg_disp = DISP_RESET;
      clear_totals();
      rho_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_MODE: reg_mode = cfg_mon.data[MODE_W-1:0];
          CFG_VPC:  reg_vpc  = cfg_mon.data[VPC_W-1:0];
          CFG_PC:   reg_pc   = cfg_mon.data[PC_W-1:0];
          default:  reg_disp = cfg_mon.data[DISP_W-1:0];
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        absorb_residual(in_mon.residual, in_mon.last, emit, est);
        if (emit) rho_due.push_back(est);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (rho_due.size() == 0) begin
          $error("rho: expected no word, actual %0d", $signed(out_mon.rho));
          fails++;
        end else begin
          due = rho_due.pop_front();
          if (out_mon.rho !== due.rho) begin
            $error("rho: expected %0d, actual %0d", $signed(due.rho), $signed(out_mon.rho));
            fails++;
          end
          if (out_mon.fallback_used !== due.fallback_used) begin
            $error("fallback_used: expected %0d, actual %0d", due.fallback_used,
                   out_mon.fallback_used);
            fails++;
          end
        end
      end
    end
    backlog = rho_due.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// testbench top for the correlation moment estimator: clock, reset, register
// writes, residual streams, output back-pressure and the verdict
// depends on gce_pkg, gce_if.sv and gce_estimate_check.sv
module tb_top import gce_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // unassigned mode code, the block answers 0 for it
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  // settle time covers the longest busy stretch, on the closing word, with margin
  localparam int SETTLE_CYCLES = 40;
  localparam int WORD_TARGET   = 1950;
  localparam int CYCLE_LIMIT   = 400000;

  // how the residuals of one data set are shaped
  typedef enum int unsigned {
    SH_CORRELATED,   // cluster base plus small noise, positive correlation
    SH_ALTERNATING,  // sign flips word to word, negative lag-1 correlation
    SH_SMALL,        // uncorrelated, near the phase scale
    SH_FULL,         // uniform over the whole residual range
    SH_EXTREME       // only range ends, zero and +-1 lsb
  } shape_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        sink_ready = 1'b0;
  int          gap_pct    = 0;
  int          stall_pct  = 0;
  int          cycles     = 0;
  int          words_sent = 0;
  int unsigned vpc_now    = VPC_RESET;
  int unsigned scale      = 256;
  int          fail_count;
  int          open_count;

  always #4 clk = ~clk;

  gce_in_if  in_ch ();
  gce_out_if out_ch ();
  gce_cfg_if cfg_ch ();

  gee_correlation_estimator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  gce_estimate_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  // output back-pressure, redrawn every cycle
  assign out_ch.ready = sink_ready;
  always @(posedge clk) begin
    sink_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic int rand_signed(int unsigned m);
    return int'($urandom_range(2 * m)) - int'(m);
  endfunction

  // cluster size as the block sees it after clamping
  function automatic int unsigned dim_now();
    if (vpc_now < 2) return 2;
    if (vpc_now > DEF_MAX_VALUES) return DEF_MAX_VALUES;
    return vpc_now;
  endfunction

  // one residual word; valid stays up between back-to-back words and only
  // drops inside a sender gap or when the stream pauses
  task automatic push_word(logic signed [RES_W-1:0] r, logic l);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid    <= 1'b0;
      in_ch.residual <= 16'($urandom);
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.residual <= r;
    in_ch.last     <= l;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // all four registers; data bits above each register's width are random
  // and must be dropped by the block
  task automatic set_regs(logic [MODE_W-1:0] m, int unsigned vpc, int unsigned pc,
                          int unsigned disp);
    write_reg(CFG_MODE, {14'($urandom), m});
    write_reg(CFG_VPC, {7'($urandom), 9'(vpc)});
    write_reg(CFG_PC, {8'($urandom), 8'(pc)});
    write_reg(CFG_DISP, 16'(disp));
    cfg_ch.valid <= 1'b0;
    vpc_now = vpc;
  endtask

  // stop feeding, wait for every estimate word, then let the block drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (open_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // whole clusters plus a partial tail; close marks the final word as last
  task automatic send_set(int unsigned clusters, int unsigned tail, bit close, shape_t sh);
    int unsigned             dim, total, pick;
    int                      base, v;
    logic signed [RES_W-1:0] prev;
    dim   = dim_now();
    total = clusters * dim + tail;
    base  = 0;
    prev  = '0;
    for (int unsigned i = 0; i < total; i++) begin
      if (i % dim == 0) base = rand_signed(scale);
      case (sh)
        SH_CORRELATED:  v = base + rand_signed(scale / 4 + 1);
        SH_ALTERNATING: v = (i % dim == 0) ? base : rand_signed(scale / 4 + 1) - int'(prev);
        SH_SMALL:       v = rand_signed(scale * 2);
        SH_FULL:        v = int'($urandom_range(65535)) - 32768;
        default: begin
          pick = $urandom_range(4);
          v = (pick == 0) ? -32768 : (pick == 1) ? 32767 : (pick == 2) ? 0 :
              (pick == 3) ? -1 : 1;
        end
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      prev = v[RES_W-1:0];
      push_word(prev, close && (i == total - 1));
    end
  endtask

  initial begin
    int unsigned       pick, clusters, tail, phase, phase_start, vpc, pc, disp;
    logic [MODE_W-1:0] m;
    shape_t            sh;
    bit                big;

    in_ch.valid    <= 1'b0;
    in_ch.residual <= '0;
    in_ch.last     <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= CFG_MODE;
    cfg_ch.data    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed words ----

    // reset settings: independence mode answers 0 even for range ends
    push_word(16'h8000, 1'b0);
    push_word(16'h7FFF, 1'b1);
    settle();

    // one pair per cluster: estimate lands exactly on +1.0, then on -1.0
    set_regs(MODE_EXCH, 2, 0, 256);
    push_word(16'sd256, 1'b0);
    push_word(16'sd256, 1'b1);
    push_word(16'sd256, 1'b0);
    push_word(-16'sd256, 1'b1);
    settle();

    // parameter count cancels the only pair: zero divisor, fallback
    set_regs(MODE_EXCH, 2, 1, 256);
    push_word(16'sd100, 1'b0);
    push_word(16'sd200, 1'b1);
    settle();

    // last arrives inside a cluster and the parameter count exceeds the
    // pair count, so the divisor goes negative
    set_regs(MODE_EXCH, 4, 255, 256);
    push_word(16'sd300, 1'b0);
    push_word(16'sd300, 1'b0);
    push_word(16'sd300, 1'b1);
    settle();

    // lag-1 products of the range ends at the widest dispersion
    set_regs(MODE_AR1, 3, 0, 65535);
    push_word(16'h7FFF, 1'b0);
    push_word(16'h8000, 1'b0);
    push_word(16'sd0, 1'b1);
    settle();

    // unassigned mode code
    set_regs(MODE_SPARE, 3, 0, 256);
    push_word(16'sd1, 1'b1);
    settle();

    // cluster size zero behaves as two; zero dispersion divides by zero
    set_regs(MODE_EXCH, 0, 0, 0);
    push_word(16'sd5, 1'b0);
    push_word(16'sd7, 1'b1);
    settle();

    // data set left open in ar1, then closed under exchangeable settings
    set_regs(MODE_AR1, 1, 0, 256);
    push_word(16'sd256, 1'b0);
    push_word(16'sd256, 1'b0);
    settle();
    set_regs(MODE_EXCH, 2, 2, 1);
    push_word(16'sd256, 1'b0);
    push_word(16'sd256, 1'b1);
    settle();

    // ---- random phases, each under fresh register settings ----
    phase = 0;
    while (words_sent < WORD_TARGET) begin
      // idling style rotates: none, sender gaps, receiver stalls, both light
      case (phase % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 68;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 68;
        end
        default: begin
          gap_pct   = 16;
          stall_pct = 16;
        end
      endcase
      // now and then a phase with the largest clusters, one data set only
      big = (phase % 8 == 5);

      pick = $urandom_range(9);
      m = (pick < 4) ? MODE_EXCH : (pick < 8) ? MODE_AR1 :
          (pick == 8) ? MODE_INDEP : MODE_SPARE;
      pick = $urandom_range(9);
      if (big)
        vpc = (pick < 5) ? DEF_MAX_VALUES : $urandom_range(511, DEF_MAX_VALUES + 1);
      else
        vpc = (pick == 0) ? $urandom_range(1) : (pick == 1) ? $urandom_range(40, 9) :
              $urandom_range(8, 2);
      pick = $urandom_range(19);
      pc = (pick < 12) ? 0 : (pick < 17) ? $urandom_range(4, 1) :
           (pick == 17) ? 255 : $urandom_range(255);
      scale = ($urandom_range(7) == 0) ? 32767 : $urandom_range(1024, 32);
      // dispersion near the residual power gives estimates inside the range
      pick = $urandom_range(9);
      case (pick)
        0: disp = 1;
        1: disp = 65535;
        2: disp = $urandom_range(65535);
        3: disp = 256;
        default: begin
          disp = scale * scale / 128 * $urandom_range(6, 2) / 4;
          if (disp > 65535) disp = 65535;
          if (disp < 1) disp = 1;
        end
      endcase
      set_regs(m, vpc, pc, disp);

      phase_start = words_sent;
      do begin
        pick = $urandom_range(9);
        sh = shape_t'((pick < 4) ? SH_CORRELATED : (pick < 6) ? SH_ALTERNATING :
                      (pick == 6) ? SH_SMALL : (pick < 9) ? SH_FULL : SH_EXTREME);
        clusters = big ? 1 : (dim_now() > 16) ? $urandom_range(2, 1) : $urandom_range(4, 1);
        tail = ($urandom_range(3) == 0) ? $urandom_range(dim_now() - 1, 1) : 0;
        if (big) tail = tail % 8;
        send_set(clusters, tail, 1'b1, sh);
      end while (!big && words_sent - phase_start < 110);

      // leave a data set open so the next settings take over mid-stream
      if ($urandom_range(3) == 0) send_set(0, $urandom_range(dim_now(), 1), 1'b0, SH_SMALL);
      settle();
      phase++;
    end

    // settle() above already drained the block; sample the count between edges
    @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
